// ===== sv/sha1_pkg.sv =====
// Shared types, constants and helper functions of the SHA-1 digest unit.
package sha1_pkg;

    localparam int unsigned NumWords       = 5;
    localparam int unsigned SchedWords     = 16;
    localparam int unsigned Rounds         = 80;
    localparam int unsigned RoundsPerPhase = 20;
    localparam int unsigned LenOffset      = 56;

    typedef logic [31:0] t_word;
    typedef logic [6:0]  t_round;
    typedef logic [5:0]  t_fill;
    typedef logic [2:0]  t_widx;
    typedef logic [7:0]  t_byte;
    typedef logic [63:0] t_len;

    localparam t_widx  LastWordIdx = t_widx'(NumWords - 1);
    localparam t_round LastRound   = t_round'(Rounds - 1);
    localparam t_fill  LastFill    = 6'h3f;
    localparam t_fill  LenFill     = t_fill'(LenOffset);
    localparam t_byte  PadMark     = 8'h80;

    localparam t_word InitHash [NumWords] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    typedef enum logic {
        OP_ABSORB = 1'b0,
        OP_FINISH = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PB_DATA,
        PB_MARK,
        PB_ZERO,
        PB_LEN
    } t_pad_sel;

    typedef enum logic [1:0] {
        PH_CH,
        PH_PAR1,
        PH_MAJ,
        PH_PAR2
    } t_phase;

    // Control bundle from the sequencer to the datapath.
    typedef struct packed {
        logic     in_ready;
        logic     out_valid;
        logic     shift_en;
        t_pad_sel pad_sel;
        logic [2:0] len_byte;
        logic     vars_load;
        logic     round_en;
        t_round   round_idx;
        logic     fold_en;
        logic     len_add;
        logic     restart;
        t_widx    word_idx;
        logic     last_word;
    } t_ctrl;

    function automatic t_phase round_phase(input t_round t);
        t_phase ph;
        priority if (t < t_round'(RoundsPerPhase))     ph = PH_CH;
        else if (t < t_round'(2 * RoundsPerPhase))     ph = PH_PAR1;
        else if (t < t_round'(3 * RoundsPerPhase))     ph = PH_MAJ;
        else                                           ph = PH_PAR2;
        return ph;
    endfunction

    function automatic t_word round_k(input t_phase ph);
        t_word k;
        unique case (ph)
            PH_CH:   k = 32'h5a827999;
            PH_PAR1: k = 32'h6ed9eba1;
            PH_MAJ:  k = 32'h8f1bbcdc;
            PH_PAR2: k = 32'hca62c1d6;
            default: k = 32'h5a827999;
        endcase
        return k;
    endfunction

endpackage

// ===== sv/sha1_if.sv =====
// Valid/ready channel interfaces for the input items and the digest words.
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface

// ===== sv/sha1_round.sv =====
// One SHA-1 round: the shared round unit, reused for all 80 rounds.
module sha1_round (
    input  sha1_pkg::t_word  i_vars [sha1_pkg::NumWords],
    input  sha1_pkg::t_word  i_w,
    input  sha1_pkg::t_phase i_phase,
    output sha1_pkg::t_word  o_vars [sha1_pkg::NumWords]
);
    import sha1_pkg::*;

    t_word a, b, c, d, e, f, tmp;

    always_comb begin
        a = i_vars[0];
        b = i_vars[1];
        c = i_vars[2];
        d = i_vars[3];
        e = i_vars[4];
        unique case (i_phase)
            PH_CH:   f = (b & c) | (~b & d);
            PH_PAR1: f = b ^ c ^ d;
            PH_MAJ:  f = (b & c) | (b & d) | (c & d);
            PH_PAR2: f = b ^ c ^ d;
            default: f = b ^ c ^ d;
        endcase
        tmp = {a[26:0], a[31:27]} + f + e + round_k(i_phase) + i_w;
    end

    assign o_vars[0] = tmp;
    assign o_vars[1] = a;
    assign o_vars[2] = {b[1:0], b[31:2]};
    assign o_vars[3] = c;
    assign o_vars[4] = d;

endmodule

// ===== sv/sha1_seq.sv =====
// Sequencer: byte fill count, padding phases, round counter and digest word counter.
module sha1_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_opcode,
    input  logic            i_out_ready,
    output sha1_pkg::t_ctrl o_ctrl
);
    import sha1_pkg::*;

    t_state r_state, n_state;
    t_fill  r_fill, n_fill;
    t_round r_t, n_t;
    t_widx  r_k, n_k;
    logic   r_mark, n_mark;
    logic   r_lenph, n_lenph;
    logic   r_pad, n_pad;
    logic   r_final, n_final;
    logic   finish_req;
    logic   len_sel;

    assign finish_req = (t_opcode'(i_in_opcode) == OP_FINISH);
    // The length field starts at byte 56 of the final block and runs to its end.
    assign len_sel    = !r_mark && (r_lenph || (r_fill == LenFill));

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_t     = r_t;
        n_k     = r_k;
        n_mark  = r_mark;
        n_lenph = r_lenph;
        n_pad   = r_pad;
        n_final = r_final;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (finish_req) begin
                        n_state = ST_PAD;
                        n_pad   = 1'b1;
                        n_mark  = 1'b1;
                        n_lenph = 1'b0;
                        n_final = 1'b0;
                    end else begin
                        n_fill = r_fill + 6'd1;
                        if (r_fill == LastFill) begin
                            n_state = ST_ROUND;
                        end
                    end
                end
            end
            ST_PAD: begin
                n_fill = r_fill + 6'd1;
                if (r_mark) begin
                    n_mark = 1'b0;
                end else if (len_sel) begin
                    n_lenph = 1'b1;
                    if (r_fill == LastFill) begin
                        n_final = 1'b1;
                    end
                end
                if (r_fill == LastFill) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_t == LastRound) begin
                    n_t     = '0;
                    n_state = ST_FOLD;
                end else begin
                    n_t = r_t + 7'd1;
                end
            end
            ST_FOLD: begin
                priority if (r_final) n_state = ST_EMIT;
                else if (r_pad)       n_state = ST_PAD;
                else                  n_state = ST_IDLE;
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    if (r_k == LastWordIdx) begin
                        n_k     = '0;
                        n_pad   = 1'b0;
                        n_final = 1'b0;
                        n_lenph = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl           = '0;
        o_ctrl.in_ready  = (r_state == ST_IDLE);
        o_ctrl.out_valid = (r_state == ST_EMIT);
        o_ctrl.len_byte  = r_fill[2:0];
        o_ctrl.round_idx = r_t;
        o_ctrl.word_idx  = r_k;
        o_ctrl.last_word = (r_k == LastWordIdx);
        o_ctrl.pad_sel   = PB_DATA;
        unique case (r_state)
            ST_IDLE: begin
                o_ctrl.shift_en = i_in_valid && !finish_req;
                o_ctrl.len_add  = i_in_valid && !finish_req;
            end
            ST_PAD: begin
                o_ctrl.shift_en = 1'b1;
                priority if (r_mark) o_ctrl.pad_sel = PB_MARK;
                else if (len_sel)    o_ctrl.pad_sel = PB_LEN;
                else                 o_ctrl.pad_sel = PB_ZERO;
            end
            ST_ROUND: o_ctrl.round_en = 1'b1;
            ST_FOLD:  o_ctrl.fold_en  = 1'b1;
            ST_EMIT:  o_ctrl.restart  = i_out_ready && (r_k == LastWordIdx);
            default:  o_ctrl.in_ready = 1'b0;
        endcase
        // The byte that completes a block starts the compression.
        o_ctrl.vars_load = o_ctrl.shift_en && (r_fill == LastFill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_t     <= '0;
            r_k     <= '0;
            r_mark  <= 1'b0;
            r_lenph <= 1'b0;
            r_pad   <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_t     <= n_t;
            r_k     <= n_k;
            r_mark  <= n_mark;
            r_lenph <= n_lenph;
            r_pad   <= n_pad;
            r_final <= n_final;
        end
    end

endmodule

// ===== sv/sha1_message_digest_unit.sv =====
// Top level of the SHA-1 digest unit: block shift line, chaining value and working variables.
//
//  channel  | dir | beat carries                          | accepted when
//  ---------+-----+---------------------------------------+---------------------------
//  i_in     | in  | opcode, data_byte                     | i_in.valid && i_in.ready
//  o_out    | out | digest_word, word_index, last_word    | o_out.valid && o_out.ready
//
// An absorb beat shifts in one byte; the beat that completes a 64-byte block also starts
// a compression (80 rounds in the single round unit, then a fold into the chaining value).
// A finish beat shifts in 9 to 72 padding bytes at one a cycle, runs one or two compressions,
// then offers five digest beats; the input stays not ready until the last one is taken.
// Reset is synchronous and returns the chaining value to the initial hash, length to zero.
// A stalled digest beat holds its payload until it is taken.
module sha1_message_digest_unit (
    input logic          i_clk,
    input logic          i_rst_n,
    sha1_in_if.sink      i_in,
    sha1_out_if.source   o_out
);
    import sha1_pkg::*;

    t_ctrl  ctrl;
    t_word  r_blk   [SchedWords];
    t_word  r_chain [NumWords];
    t_word  r_var   [NumWords];
    t_word  round_out [NumWords];
    t_len   r_len;
    t_byte  shift_byte;
    t_word  sched_mix;
    t_word  sched_next;

    sha1_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .i_out_ready (o_out.ready),
        .o_ctrl      (ctrl)
    );

    sha1_round u_round (
        .i_vars  (r_var),
        .i_w     (r_blk[0]),
        .i_phase (round_phase(ctrl.round_idx)),
        .o_vars  (round_out)
    );

    always_comb begin
        unique case (ctrl.pad_sel)
            PB_DATA: shift_byte = i_in.data_byte;
            PB_MARK: shift_byte = PadMark;
            PB_ZERO: shift_byte = '0;
            // Big-endian length: byte 56 carries bits 63..56.
            PB_LEN:  shift_byte = r_len[{~ctrl.len_byte, 3'b000} +: 8];
            default: shift_byte = '0;
        endcase
    end

    // The shift line holds W[t]..W[t+15] during round t, so the taps sit at fixed places.
    assign sched_mix  = r_blk[13] ^ r_blk[8] ^ r_blk[2] ^ r_blk[0];
    assign sched_next = {sched_mix[30:0], sched_mix[31]};

    always_ff @(posedge i_clk) begin
        if (ctrl.shift_en) begin
            for (int i = 0; i < SchedWords - 1; i++) begin
                r_blk[i] <= {r_blk[i][23:0], r_blk[i + 1][31:24]};
            end
            r_blk[SchedWords - 1] <= {r_blk[SchedWords - 1][23:0], shift_byte};
        end else if (ctrl.round_en) begin
            for (int i = 0; i < SchedWords - 1; i++) begin
                r_blk[i] <= r_blk[i + 1];
            end
            r_blk[SchedWords - 1] <= sched_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.vars_load) begin
            r_var <= r_chain;
        end else if (ctrl.round_en) begin
            r_var <= round_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ctrl.restart) begin
            r_chain <= InitHash;
        end else if (ctrl.fold_en) begin
            for (int i = 0; i < NumWords; i++) begin
                r_chain[i] <= r_chain[i] + r_var[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ctrl.restart) begin
            r_len <= '0;
        end else if (ctrl.len_add) begin
            r_len <= r_len + 64'd8;
        end
    end

    assign i_in.ready        = ctrl.in_ready;
    assign o_out.valid       = ctrl.out_valid;
    assign o_out.digest_word = r_chain[ctrl.word_idx];
    assign o_out.word_index  = ctrl.word_idx;
    assign o_out.last_word   = ctrl.last_word;

endmodule

// ===== sv/sha1_chk.sv =====
// Port-level checks of the SHA-1 digest unit, bound to the top level.
module sha1_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_digest_word,
    input logic [2:0]  i_word_index,
    input logic        i_last_word
);
    import sha1_pkg::*;

    // No input beat is taken while digest words are being offered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_out_valid && i_in_ready))
        else $error("input ready while digest words are pending");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last_word == (i_word_index == LastWordIdx)))
        else $error("last_word does not match word_index");

    // The five words come back to back in index order.
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last_word) |=>
            (i_out_valid && (i_word_index == $past(i_word_index) + 3'd1)))
        else $error("digest words out of order");

    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_last_word) |=> (i_in_ready && !i_out_valid))
        else $error("unit not idle after the last digest word");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_digest_word)))
        else $error("stalled digest beat changed");

endmodule

bind sha1_message_digest_unit sha1_chk u_sha1_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_digest_word (o_out.digest_word),
    .i_word_index  (o_out.word_index),
    .i_last_word   (o_out.last_word)
);
